// ----- rtl/core/vrb_pkg.sv -----
// shared constants and types for the version reorder buffer
package vrb_pkg;

  localparam int RING_SIZE_DEF = 32;
  localparam int TAG_BITS_DEF  = 16;

  localparam int VER_W       = 64;
  localparam int TAG_FIELD_W = 16;
  localparam int WAIT_W      = 6;
  localparam int STATUS_W    = 3;
  localparam int ACTION_W    = 2;

  // input tdata layout: version_first, version_last, record_tag, order_mode
  localparam int IN_FIRST_LSB = 0;
  localparam int IN_LAST_LSB  = IN_FIRST_LSB + VER_W;
  localparam int IN_TAG_LSB   = IN_LAST_LSB + VER_W;
  localparam int IN_MODE_BIT  = IN_TAG_LSB + TAG_FIELD_W;
  localparam int IN_TDATA_W   = ((IN_MODE_BIT + 1 + 7) / 8) * 8;

  // output tdata layout: out_tag, out_first, out_last, waiting
  localparam int OUT_TAG_LSB   = 0;
  localparam int OUT_FIRST_LSB = OUT_TAG_LSB + TAG_FIELD_W;
  localparam int OUT_LAST_LSB  = OUT_FIRST_LSB + VER_W;
  localparam int OUT_WAIT_LSB  = OUT_LAST_LSB + VER_W;
  localparam int OUT_TDATA_W   = ((OUT_WAIT_LSB + WAIT_W + 7) / 8) * 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_RECORD   = 2'd0,
    ACT_SET_NEXT = 2'd1,
    ACT_SET_MODE = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_WRITTEN   = 3'd0,
    ST_STALE     = 3'd1,
    ST_REJECTED  = 3'd2,
    ST_PARKED    = 3'd3,
    ST_DIRECTIVE = 3'd4
  } status_t;

endpackage

// ----- rtl/core/vrb_mod.sv -----
// version modulo ring size: mask for a power of two, else four bits per cycle
module vrb_mod #(
  parameter int RING_SIZE = vrb_pkg::RING_SIZE_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [vrb_pkg::VER_W-1:0]    value,
  output logic                         done,
  output logic [$clog2(RING_SIZE)-1:0] rem
);

  localparam int IdxW   = $clog2(RING_SIZE);
  localparam bit IsPow2 = ((RING_SIZE & (RING_SIZE - 1)) == 0);
  localparam int DigW   = 4;
  localparam int Steps  = vrb_pkg::VER_W / DigW;
  localparam int CntW   = $clog2(Steps);

  logic            done_r;
  logic [IdxW-1:0] rem_r;

  assign done = done_r;
  assign rem  = rem_r;

  generate
    if (IsPow2) begin : g_mask
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
        if (start) begin
          rem_r <= value[IdxW-1:0];
        end
      end
    end else begin : g_serial
      logic                      busy_r;
      logic [CntW-1:0]           cnt_r;
      logic [vrb_pkg::VER_W-1:0] sh_r;
      logic [IdxW-1:0]           step_rem;

      // one digit of the dividend folded into the remainder per cycle
      always_comb begin
        logic [IdxW:0] t;
        t        = '0;
        step_rem = rem_r;
        for (int i = 0; i < DigW; i++) begin
          t = {step_rem, sh_r[vrb_pkg::VER_W-1-i]};
          if (t >= (IdxW+1)'(RING_SIZE)) begin
            t = t - (IdxW+1)'(RING_SIZE);
          end
          step_rem = t[IdxW-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          busy_r <= 1'b0;
          done_r <= 1'b0;
          cnt_r  <= '0;
        end else begin
          done_r <= 1'b0;
          if (start) begin
            busy_r <= 1'b1;
            cnt_r  <= '0;
          end else if (busy_r) begin
            cnt_r <= cnt_r + 1'b1;
            if (cnt_r == CntW'(Steps - 1)) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
        end
        if (start) begin
          sh_r  <= value;
          rem_r <= '0;
        end else if (busy_r) begin
          sh_r  <= sh_r << DigW;
          rem_r <= step_rem;
        end
      end
    end
  endgenerate

endmodule

// ----- rtl/core/version_reorder_buffer_core.sv -----
// version reorder buffer: puts version-tagged records out in version order
//
// input channel in_*: one beat is a record or a directive, kind in in_tuser
// (0 record, 1 set next version, 2 set order mode). result channel out_*:
// one beat per result, status in out_tuser, out_tlast on the final result
// that an input beat causes. action code 3 is dropped with no result.
// a record one to RING_SIZE-1 versions ahead is parked in a ring of slots;
// a record starting at the next version is written and then parked records
// that now follow on are drained from the ring, one beat each.
// one beat is taken at a time: in_tready is high only while the sequencer
// idles. a directive, stale, out-of-window or pass-through record goes from
// IDLE through DECIDE and EMIT back to IDLE; parking and each drained record
// go through the shared modulo unit, a mask when RING_SIZE is a power of
// two and a serial divider otherwise, plus a slot read.
// results leave through an output register, so a finished beat waits there
// while the next input beat is accepted; a stalled receiver holds the
// sequencer only where it has a further result to hand over.
// reset (rst_n low, synchronous) clears the next version to zero, selects
// ordered mode and empties the ring; no clearing pass is needed.
module version_reorder_buffer_core #(
  parameter int RING_SIZE = vrb_pkg::RING_SIZE_DEF,
  parameter int TAG_BITS  = vrb_pkg::TAG_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // version_first, version_last, record_tag, order_mode
  input  logic [vrb_pkg::IN_TDATA_W-1:0]   in_tdata,
  // action
  input  logic [vrb_pkg::ACTION_W-1:0]     in_tuser,
  // result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_tag, out_first, out_last, waiting
  output logic [vrb_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // status
  output logic [vrb_pkg::STATUS_W-1:0]     out_tuser,
  // last_of_run
  output logic                             out_tlast
);

  localparam int IdxW = $clog2(RING_SIZE);
  localparam int TagW = (TAG_BITS < vrb_pkg::TAG_FIELD_W) ? TAG_BITS : vrb_pkg::TAG_FIELD_W;
  localparam int VerW = vrb_pkg::VER_W;
  localparam int WaitW = vrb_pkg::WAIT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_PMOD,
    S_DMOD,
    S_DCHK,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [VerW-1:0] first;
    logic [VerW-1:0] last;
    logic [TagW-1:0] tag;
  } slot_t;

  state_t state_r;

  // latched input beat
  vrb_pkg::action_t act_r;
  logic [VerW-1:0]  first_r;
  logic [VerW-1:0]  last_r;
  logic [TagW-1:0]  tag_r;
  logic             mode_r;

  // ordering state
  logic [VerW-1:0]      next_r;
  logic                 ordered_r;
  logic [RING_SIZE-1:0] slot_valid_r;
  logic [WaitW-1:0]     waiting_r;

  // result held until it is known whether another one follows
  logic [TagW-1:0]        pend_tag_r;
  logic [VerW-1:0]        pend_first_r;
  logic [VerW-1:0]        pend_last_r;
  vrb_pkg::status_t       pend_status_r;
  logic [WaitW-1:0]       pend_wait_r;

  // output register
  logic                           out_valid_r;
  logic [vrb_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic [vrb_pkg::STATUS_W-1:0]   out_user_r;
  logic                           out_last_r;

  // slot memory
  slot_t slot_mem [RING_SIZE];
  slot_t rd_r;

  logic            mod_start;
  logic [VerW-1:0] mod_value;
  logic            mod_done;
  logic [IdxW-1:0] mod_rem;

  logic [VerW-1:0] ahead;
  logic            is_stale;
  logic            is_head;
  logic            in_window;
  logic            drain_hit;
  logic            out_free;
  logic            push;
  logic            push_last;
  logic            slot_we;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    ahead     = first_r - next_r;
    is_stale  = first_r < next_r;
    is_head   = first_r == next_r;
    in_window = ahead < VerW'(RING_SIZE);
    drain_hit = slot_valid_r[mod_rem] && (rd_r.first == next_r);

    mod_start = 1'b0;
    if (state_r == S_DECIDE && act_r == vrb_pkg::ACT_RECORD && ordered_r &&
        !is_stale && (is_head || in_window)) begin
      mod_start = 1'b1;
    end
    if (state_r == S_DCHK && out_free && drain_hit) begin
      mod_start = 1'b1;
    end
    // the modulo source is the new next version after a write, or the
    // parking record's first version
    if (state_r == S_DCHK) begin
      mod_value = rd_r.last + 1'b1;
    end else if (is_head) begin
      mod_value = last_r + 1'b1;
    end else begin
      mod_value = first_r;
    end

    push      = out_free && (state_r == S_EMIT || state_r == S_DCHK);
    push_last = (state_r == S_EMIT) || !drain_hit;
    slot_we   = (state_r == S_PMOD) && mod_done && !slot_valid_r[mod_rem];
  end

  vrb_mod #(
    .RING_SIZE (RING_SIZE)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .value (mod_value),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  // slot storage: registered read at the current modulo result
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[mod_rem] <= '{first: first_r, last: last_r, tag: tag_r};
    end
    rd_r <= slot_mem[mod_rem];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      next_r       <= '0;
      ordered_r    <= 1'b1;
      slot_valid_r <= '0;
      waiting_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // output register: drained by the receiver, refilled on a push
      if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          priority case (act_r)
            vrb_pkg::ACT_SET_NEXT: begin
              next_r  <= first_r;
              state_r <= S_EMIT;
            end
            vrb_pkg::ACT_SET_MODE: begin
              ordered_r <= mode_r;
              state_r   <= S_EMIT;
            end
            vrb_pkg::ACT_RECORD: begin
              if (!ordered_r || is_stale) begin
                state_r <= S_EMIT;
              end else if (is_head) begin
                // written at once, then look for a follower in the ring
                next_r  <= last_r + 1'b1;
                state_r <= S_DMOD;
              end else if (in_window) begin
                state_r <= S_PMOD;
              end else begin
                state_r <= S_EMIT;
              end
            end
            default: begin
              state_r <= S_IDLE;
            end
          endcase
        end

        S_PMOD: begin
          if (mod_done) begin
            if (!slot_valid_r[mod_rem]) begin
              slot_valid_r[mod_rem] <= 1'b1;
              waiting_r             <= waiting_r + 1'b1;
            end
            state_r <= S_EMIT;
          end
        end

        S_DMOD: begin
          if (mod_done) begin
            state_r <= S_DCHK;
          end
        end

        S_DCHK: begin
          if (out_free) begin
            if (drain_hit) begin
              slot_valid_r[mod_rem] <= 1'b0;
              waiting_r             <= waiting_r - 1'b1;
              next_r                <= rd_r.last + 1'b1;
              state_r               <= S_DMOD;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end

        S_EMIT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end

    // payload registers
    if (state_r == S_IDLE && in_tvalid) begin
      act_r   <= vrb_pkg::action_t'(in_tuser);
      first_r <= in_tdata[vrb_pkg::IN_FIRST_LSB +: VerW];
      last_r  <= in_tdata[vrb_pkg::IN_LAST_LSB +: VerW];
      tag_r   <= in_tdata[vrb_pkg::IN_TAG_LSB +: TagW];
      mode_r  <= in_tdata[vrb_pkg::IN_MODE_BIT];
    end

    if (push) begin
      out_data_r <= '0;
      out_data_r[vrb_pkg::OUT_TAG_LSB +: vrb_pkg::TAG_FIELD_W] <=
        vrb_pkg::TAG_FIELD_W'(pend_tag_r);
      out_data_r[vrb_pkg::OUT_FIRST_LSB +: VerW] <= pend_first_r;
      out_data_r[vrb_pkg::OUT_LAST_LSB +: VerW]  <= pend_last_r;
      out_data_r[vrb_pkg::OUT_WAIT_LSB +: WaitW] <= pend_wait_r;
      out_user_r <= pend_status_r;
      out_last_r <= push_last;
    end

    // pending result
    if (state_r == S_DECIDE) begin
      pend_tag_r   <= tag_r;
      pend_first_r <= first_r;
      pend_last_r  <= last_r;
      pend_wait_r  <= waiting_r;
      if (act_r == vrb_pkg::ACT_SET_NEXT) begin
        pend_tag_r    <= '0;
        pend_last_r   <= first_r;
        pend_status_r <= vrb_pkg::ST_DIRECTIVE;
      end else if (act_r == vrb_pkg::ACT_SET_MODE) begin
        pend_tag_r    <= '0;
        pend_first_r  <= VerW'(mode_r);
        pend_last_r   <= VerW'(mode_r);
        pend_status_r <= vrb_pkg::ST_DIRECTIVE;
      end else if (!ordered_r || is_head) begin
        pend_status_r <= vrb_pkg::ST_WRITTEN;
      end else if (is_stale) begin
        pend_status_r <= vrb_pkg::ST_STALE;
      end else begin
        // out of window until the slot check says otherwise
        pend_status_r <= vrb_pkg::ST_REJECTED;
      end
    end else if (state_r == S_PMOD && mod_done && !slot_valid_r[mod_rem]) begin
      pend_status_r <= vrb_pkg::ST_PARKED;
      pend_wait_r   <= waiting_r + 1'b1;
    end else if (state_r == S_DCHK && out_free && drain_hit) begin
      pend_tag_r    <= rd_r.tag;
      pend_first_r  <= rd_r.first;
      pend_last_r   <= rd_r.last;
      pend_status_r <= vrb_pkg::ST_WRITTEN;
      pend_wait_r   <= waiting_r - 1'b1;
    end
  end

endmodule

// ----- test/tb_version_reorder_buffer_core.sv -----
// self-checking testbench for the version reorder buffer core
module tb_version_reorder_buffer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import vrb_pkg::*;

  // ring and tag size as built into the block (default parameters)
  localparam int RING = RING_SIZE_DEF;
  localparam logic [TAG_FIELD_W-1:0] TAG_KEEP =
    (TAG_BITS_DEF >= TAG_FIELD_W) ? '1 : TAG_FIELD_W'((1 << TAG_BITS_DEF) - 1);

  // action code with no meaning: the block drops the beat without a result
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  localparam logic [VER_W-1:0] VER_MAX = '1;

  localparam int RANDOM_BEATS = 430;
  localparam int QUIET_BEATS  = 40;    // final stretch of input beats with no idling
  localparam int HOLD_AT      = 150;   // input beat count that starts the long hold-off
  localparam int LONG_HOLD    = 300;   // receiver hold-off length in cycles
  localparam int IDLE_LIMIT   = 5000;  // cycles without any beat before giving up
  localparam int TAIL_CYCLES  = 64;    // settle time once nothing is expected
  localparam int MAX_REPORTS  = 10;

  // one input beat before packing
  typedef struct {
    logic [ACTION_W-1:0]    action;
    logic [VER_W-1:0]       first;
    logic [VER_W-1:0]       last;
    logic [TAG_FIELD_W-1:0] tag;
    logic                   mode;
  } beat_t;

  // one result beat as the block should hand it over
  typedef struct {
    logic [TAG_FIELD_W-1:0] tag;
    logic [VER_W-1:0]       first;
    logic [VER_W-1:0]       last;
    status_t                status;
    logic [WAIT_W-1:0]      waiting;
    logic                   tlast;
  } release_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // version_first, version_last, record_tag, order_mode
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  // action
  logic [ACTION_W-1:0]    in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // out_tag, out_first, out_last, waiting
  logic [OUT_TDATA_W-1:0] out_tdata;
  // status
  logic [STATUS_W-1:0]    out_tuser;
  logic                   out_tlast;

  version_reorder_buffer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor state: mirrors the block from reset on (reset happens only once)
  // ---------------------------------------------------------------------------
  logic [VER_W-1:0]       exp_next = '0;
  logic                   exp_ordered = 1'b1;
  logic                   ring_valid [RING] = '{default: 1'b0};
  logic [VER_W-1:0]       ring_first [RING];
  logic [VER_W-1:0]       ring_last  [RING];
  logic [TAG_FIELD_W-1:0] ring_tag   [RING];
  int                     ring_count = 0;

  beat_t    beat_q[$];     // beats still to be offered
  release_t release_q[$];  // results owed by the block, oldest first
  beat_t    cur_beat;      // beat currently on the input bus

  int in_taken = 0;        // input beats accepted (nba, read by other processes)
  int total_beats = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;
  int mismatches = 0;
  int results_seen = 0;

  // no idling near the end of the run and in every third stretch of 64 beats
  wire no_idle = (in_taken + QUIET_BEATS >= total_beats) || ((in_taken / 64) % 3 == 2);

  function automatic logic [VER_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [TAG_FIELD_W-1:0] rand_tag();
    return TAG_FIELD_W'($urandom_range(0, 65535));
  endfunction

  // owed result; waiting reflects the ring occupancy at the moment it is made
  function automatic void push_release(logic [TAG_FIELD_W-1:0] tag, logic [VER_W-1:0] f,
                                       logic [VER_W-1:0] l, status_t st);
    release_t r;
    r.tag     = tag & TAG_KEEP;
    r.first   = f;
    r.last    = l;
    r.status  = st;
    r.waiting = WAIT_W'(ring_count);
    r.tlast   = 1'b0;
    release_q.push_back(r);
  endfunction

  // work out every result that one accepted beat causes
  task automatic release_for_beat(input beat_t b);
    int               made_before;
    int               idx;
    logic [VER_W-1:0] f;
    logic [VER_W-1:0] l;
    logic [VER_W-1:0] ahead;
    release_t         r;
    made_before = release_q.size();
    case (b.action)
      ACT_SET_NEXT: begin
        // in ordered mode an unchanged value is a no-op; parked records stay put
        if (!exp_ordered || exp_next != b.first) exp_next = b.first;
        push_release('0, b.first, b.first, ST_DIRECTIVE);
      end
      ACT_SET_MODE: begin
        exp_ordered = b.mode;
        push_release('0, VER_W'(b.mode), VER_W'(b.mode), ST_DIRECTIVE);
      end
      ACT_RECORD: begin
        if (!exp_ordered) begin
          push_release(b.tag, b.first, b.last, ST_WRITTEN);
        end else if (b.first < exp_next) begin
          push_release(b.tag, b.first, b.last, ST_STALE);
        end else if (b.first == exp_next) begin
          // write, then drain parked records that now follow on
          exp_next = exp_next + (b.last - b.first) + 64'd1;
          push_release(b.tag, b.first, b.last, ST_WRITTEN);
          idx = int'(exp_next % RING);
          while (ring_valid[idx] && ring_first[idx] == exp_next) begin
            f = ring_first[idx];
            l = ring_last[idx];
            ring_valid[idx] = 1'b0;
            if (ring_count > 0) ring_count--;
            exp_next = exp_next + (l - f) + 64'd1;
            push_release(ring_tag[idx], f, l, ST_WRITTEN);
            idx = int'(exp_next % RING);
          end
        end else begin
          // ahead of the next version: park if inside the window and the slot is free
          ahead = b.first - exp_next;
          idx = int'(b.first % RING);
          if (ahead >= RING || ring_valid[idx]) begin
            push_release(b.tag, b.first, b.last, ST_REJECTED);
          end else begin
            ring_valid[idx] = 1'b1;
            ring_first[idx] = b.first;
            ring_last[idx]  = b.last;
            ring_tag[idx]   = b.tag & TAG_KEEP;
            ring_count++;
            push_release(b.tag, b.first, b.last, ST_PARKED);
          end
        end
      end
      default: begin
        // unused action code: nothing comes out
      end
    endcase
    if (release_q.size() > made_before) begin
      r = release_q.pop_back();
      r.tlast = 1'b1;
      release_q.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus builders: fields a beat does not use are random
  // ---------------------------------------------------------------------------
  task automatic queue_record(input logic [VER_W-1:0] f, input logic [VER_W-1:0] l,
                              input logic [TAG_FIELD_W-1:0] t);
    beat_t b;
    b.action = ACT_RECORD;
    b.first  = f;
    b.last   = l;
    b.tag    = t;
    b.mode   = 1'($urandom_range(0, 1));
    beat_q.push_back(b);
  endtask

  task automatic queue_set_next(input logic [VER_W-1:0] v);
    beat_t b;
    b.action = ACT_SET_NEXT;
    b.first  = v;
    b.last   = rand64();
    b.tag    = rand_tag();
    b.mode   = 1'($urandom_range(0, 1));
    beat_q.push_back(b);
  endtask

  task automatic queue_set_mode(input logic m);
    beat_t b;
    b.action = ACT_SET_MODE;
    b.first  = rand64();
    b.last   = rand64();
    b.tag    = rand_tag();
    b.mode   = m;
    beat_q.push_back(b);
  endtask

  task automatic queue_unused();
    beat_t b;
    b.action = ACT_UNUSED;
    b.first  = rand64();
    b.last   = rand64();
    b.tag    = rand_tag();
    b.mode   = 1'($urandom_range(0, 1));
    beat_q.push_back(b);
  endtask

  // noise inside a run whose next version lies in [base, base+RING]:
  // nothing here can land inside the window, so the run still drains fully
  task automatic queue_noise(input logic [VER_W-1:0] base, input logic [VER_W-1:0] f,
                             input logic [VER_W-1:0] l);
    case ($urandom_range(0, 3))
      0: queue_record(base - 64'd1 - 64'($urandom_range(0, 40)), rand64(), rand_tag());
      1: queue_record(base + 64'(2 * RING) + rand64() % (64'd0 - 64'(4 * RING)),
                      rand64(), rand_tag());
      // repeat of a piece already sent: stale if written, slot taken if parked
      2: queue_record(f, l, rand_tag());
      default: queue_unused();
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [VER_W-1:0] base;
    logic [VER_W-1:0] pos;
    logic [VER_W-1:0] gen_next;
    logic [VER_W-1:0] pf [RING];
    logic [VER_W-1:0] pl [RING];
    int               perm [RING];
    int               target;
    int               cnt;
    int               span;
    int               len;
    int               n;
    int               pick;
    int               style;
    int               tmp;
    bit               gen_known;
    bit               cont;
    bit               full_ring;
    bit               crosses;
    bit               first_full;

    // directed: reset state, stale, parking, slot taken, window edge, drain
    queue_record(64'd0, 64'd0, 16'hFFFF);                   // next version is zero after reset
    queue_record(64'd3, 64'd3, 16'h0000);                   // parked
    queue_record(64'd3, 64'd4, 16'h1234);                   // same slot again: rejected
    queue_record(64'd1, 64'd2, rand_tag());                 // written, drains the parked one
    queue_record(64'd0, 64'd5, rand_tag());                 // stale
    queue_record(64'(4 + RING), 64'(4 + RING), rand_tag()); // one window ahead: rejected
    queue_record(64'(3 + RING), 64'(3 + RING), rand_tag()); // last slot of the window: parked
    queue_set_next(64'd100);                                // jump leaves that record behind
    queue_set_next(64'd100);                                // unchanged value
    // step back and write up to the left-behind record so it drains
    queue_set_next(64'(RING - 2));
    queue_record(64'(RING - 2), 64'(RING + 2), rand_tag());
    queue_unused();
    // unordered pass-through with extreme fields
    queue_set_mode(1'b0);
    queue_record(VER_MAX, VER_MAX, 16'hFFFF);
    queue_record(64'd0, VER_MAX, 16'h0000);
    queue_set_next(64'd7);
    queue_set_mode(1'b1);
    // next version wraps past the top of the range
    queue_set_next(VER_MAX - 64'd1);
    queue_record(VER_MAX - 64'd1, VER_MAX, rand_tag());
    queue_record(64'd1, 64'd1, rand_tag());
    queue_record(64'd0, 64'd0, rand_tag());
    // zero version count: last one below first
    queue_set_next(64'd50);
    queue_record(64'd50, 64'd49, rand_tag());
    gen_next  = 64'd50;
    gen_known = 1'b1;

    // random runs: mostly contiguous version runs offered out of order
    target = beat_q.size() + RANDOM_BEATS;
    first_full = 1'b1;
    while (beat_q.size() < target) begin
      if ($urandom_range(0, 9) == 0) begin
        // unordered stretch, then back to ordered with an unknown next version
        queue_set_mode(1'b0);
        n = $urandom_range(1, 8);
        repeat (n) begin
          if ($urandom_range(0, 4) == 0) queue_set_next(rand64());
          else queue_record(rand64(), rand64(), rand_tag());
        end
        queue_set_mode(1'b1);
        gen_known = 1'b0;
      end else begin
        pick = $urandom_range(0, 3);
        cont = gen_known && pick == 0;
        case (pick)
          0: base = gen_next;
          1: base = rand64();
          2: base = VER_MAX - 64'($urandom_range(0, 40));
          default: base = 64'($urandom_range(0, 5000));
        endcase
        if (!cont || $urandom_range(0, 1) == 0) queue_set_next(base);

        // cut the run into pieces spanning at most one window
        full_ring = first_full || $urandom_range(0, 19) == 0;
        first_full = 1'b0;
        n = full_ring ? RING : $urandom_range(1, 12);
        cnt = 0;
        span = 0;
        pos = base;
        while (cnt < n && span < RING) begin
          len = (full_ring || $urandom_range(0, 3) != 0) ? 1 : $urandom_range(2, 4);
          if (span + len > RING) len = RING - span;
          pf[cnt] = pos;
          pl[cnt] = pos + 64'(len) - 64'd1;
          pos = pos + 64'(len);
          span += len;
          cnt++;
        end

        // a run crossing the top of the range goes in order: wrapped pieces
        // offered early would compare as stale
        crosses = (pos < base) && (pos != 0);
        style = crosses ? 0 : (full_ring ? 1 : $urandom_range(0, 3));
        for (int i = 0; i < cnt; i++) begin
          if (style == 1) perm[i] = cnt - 1 - i;        // reversed: fills the ring
          else if (style == 3) perm[i] = (i + 1) % cnt; // first piece held to the end
          else perm[i] = i;
        end
        if (style >= 2) begin
          for (int i = (style == 3 ? cnt - 2 : cnt - 1); i > 0; i--) begin
            pick = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[pick];
            perm[pick] = tmp;
          end
        end

        for (int i = 0; i < cnt; i++) begin
          queue_record(pf[perm[i]], pl[perm[i]], rand_tag());
          if ($urandom_range(0, 7) == 0) queue_noise(base, pf[perm[i]], pl[perm[i]]);
        end
        gen_next  = pos;
        gen_known = 1'b1;
      end
    end
    total_beats = beat_q.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // all beats offered and taken, every owed result handed over
    do @(negedge clk);
    while (!timed_out && (beat_q.size() != 0 || in_tvalid || release_q.size() != 0));
    // an unused-action beat may still be in flight, and late extras must show up
    repeat (TAIL_CYCLES) @(negedge clk);

    if (timed_out) $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
    if (release_q.size() != 0) $display("%0d expected results never arrived", release_q.size());
    if (!timed_out && mismatches == 0 && release_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // input driver: random gap bursts, holds the beat until it is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        release_for_beat(cur_beat);
        in_taken <= in_taken + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (beat_q.size() != 0 && !no_idle && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 6);
          in_tvalid <= 1'b0;
        end else if (beat_q.size() != 0) begin
          cur_beat = beat_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {{(IN_TDATA_W - IN_MODE_BIT - 1){1'b0}}, cur_beat.mode, cur_beat.tag,
                        cur_beat.last, cur_beat.first};
          in_tuser  <= cur_beat.action;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: compares each beat with the oldest owed result
  // ---------------------------------------------------------------------------
  task automatic check_release();
    release_t want;
    release_t got;
    got.tag     = out_tdata[OUT_TAG_LSB +: TAG_FIELD_W];
    got.first   = out_tdata[OUT_FIRST_LSB +: VER_W];
    got.last    = out_tdata[OUT_LAST_LSB +: VER_W];
    got.waiting = out_tdata[OUT_WAIT_LSB +: WAIT_W];
    got.status  = status_t'(out_tuser);
    got.tlast   = out_tlast;
    results_seen++;
    if (release_q.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("result %0d not expected: tag %h first %h last %h status %0d waiting %0d tlast %0b",
                 results_seen, got.tag, got.first, got.last, got.status, got.waiting, got.tlast);
    end else begin
      want = release_q.pop_front();
      if (want.tag != got.tag || want.first != got.first || want.last != got.last ||
          want.status != got.status || want.waiting != got.waiting || want.tlast != got.tlast) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("result %0d mismatch", results_seen);
          $display("  expected tag %h first %h last %h status %0d waiting %0d tlast %0b",
                   want.tag, want.first, want.last, want.status, want.waiting, want.tlast);
          $display("  actual   tag %h first %h last %h status %0d waiting %0d tlast %0b",
                   got.tag, got.first, got.last, got.status, got.waiting, got.tlast);
        end
      end
    end
  endtask

  // receiver: random stall bursts, fully blocked during the long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_release();
      if (hold_left != 0) begin
        out_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // one long hold-off while the sender keeps offering, so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && in_taken == HOLD_AT) begin
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // watchdog: cycles in which no beat moves on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) timed_out <= 1'b1;
  end

endmodule

// ----- version_reorder_buffer_core.f -----
rtl/core/vrb_pkg.sv
rtl/core/vrb_mod.sv
rtl/core/version_reorder_buffer_core.sv
test/tb_version_reorder_buffer_core.sv
